// ----- sv/srg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

	localparam int unsigned LEN     = 55;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned PTR_W   = 6;
	localparam int unsigned WORD_W  = 31;

	localparam logic [WORD_W-1:0] MOD        = 31'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] SEED_CONST = 31'd161803398;
	localparam logic [PTR_W-1:0]  SCATTER    = 6'd21;
	localparam logic [PTR_W-1:0]  LAG_OFS    = 6'd30;
	localparam logic [PTR_W-1:0]  TRAIL_INIT = 6'd31;
	localparam logic [PTR_W-1:0]  LAST_POS   = 6'd55;
	localparam logic [PTR_W-1:0]  LAST_FILL  = 6'd54;

	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_DIFF,
		ST_SEED_FIRST,
		ST_FILL,
		ST_MIX,
		ST_MIX_DRAIN,
		ST_DRAW_RD,
		ST_DRAW_SUB,
		ST_DRAW_MUL,
		ST_DRAW_DIV1,
		ST_DRAW_DIV2,
		ST_DRAW_OUT
	} state_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr_a;
		logic [IDX_W-1:0]  raddr_b;
	} ram_ctl_t;

	// (a - b) mod (2^31 - 1) for a, b below the modulus
	function automatic logic [WORD_W-1:0] mod_sub(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		return d[WORD_W] ? d[WORD_W-1:0] - 31'd1 : d[WORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- sv/subtractive_random_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Subtractive lagged random generator, 55-word table, modulus 2^31-1.
// A command is taken on a rising edge with start high and busy low.
// command = 0 reseeds from seed_value: the table is filled in scatter order,
// mixed four times and the pointers are set. No result. busy stays high
// through the setup states SEED_DIFF and SEED_FIRST, 54 fill writes, 220 mixing
// steps (one per cycle on the table RAM's two read ports and its write port,
// reads one step ahead of the write) and the drain state MIX_DRAIN.
// command = 1 draws: both table words are read, the difference is written
// back, then scaled into range_low..range_high by a 31x32 multiply and a
// folded division by 2^31-1. drawn_value is valid for one cycle with valid
// high after the DRAW_RD, SUB, MUL, DIV1, DIV2 and OUT states, in which busy is high.
// A new command may be given in the cycle valid is high; no command is taken
// while a draw is still running in those states.
// The receiver cannot stall; a result must be taken in its strobe cycle.
// After reset the table reads as all zeros until the first reseed, so a draw
// returns range_low and both pointers start at 0.

module subtractive_random_generator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               command,
	input  wire logic signed [31:0] seed_value,
	input  wire logic signed [31:0] range_low,
	input  wire logic signed [31:0] range_high,
	output logic                    valid,
	output logic signed [31:0]      drawn_value
);

	localparam int unsigned IW = srg_pkg::IDX_W;
	localparam int unsigned PW = srg_pkg::PTR_W;
	localparam int unsigned WW = srg_pkg::WORD_W;

	srg_pkg::state_t   state_q, state_nxt;
	srg_pkg::ram_ctl_t ram;

	logic [WW-1:0] rdata_a, rdata_b;
	logic          accept;

	// control
	logic          seeded_q;
	logic          valid_q;
	logic          mix_wr_s1;
	logic [PW-1:0] lead_q, trail_q;
	logic [PW-1:0] i_q;
	logic [PW-1:0] pos_q;
	logic [1:0]    pass_q;

	// payload
	logic [IW-1:0]      mix_idx_s1;
	logic [31:0]        seedabs_q;
	logic [32:0]        diff_q;
	logic [WW-1:0]      cur_q, prev_q;
	logic [31:0]        lo_q;
	logic signed [33:0] range_q;
	logic [32:0]        absr_q;
	logic               neg_q;
	logic [WW-1:0]      r_q;
	logic [62:0]        mag_q;
	logic [31:0]        a_q;
	logic [32:0]        s_q;
	logic [32:0]        q_q;
	logic               nz_q;
	logic [31:0]        drawn_q;

	logic [WW-1:0] seed_cur;
	logic [WW-1:0] draw_r;
	logic [IW-1:0] mix_other;
	logic [6:0]    pos_sum;
	logic [PW-1:0] pos_nxt;
	logic [PW-1:0] lead_nxt, trail_nxt;
	logic [31:0]   div_t;
	logic          div_c;
	logic [31:0]   q_sel;
	logic [6:0]    other_sum;

	assign accept = start && (state_q == srg_pkg::ST_IDLE);
	assign busy   = (state_q != srg_pkg::ST_IDLE);
	assign valid  = valid_q;
	assign drawn_value = drawn_q;

	assign seed_cur = diff_q[32] ? WW'(33'd0 - diff_q) : diff_q[WW-1:0];

	// entries read as zero before the first reseed
	assign draw_r = seeded_q ? srg_pkg::mod_sub(rdata_a, rdata_b) : '0;

	assign other_sum = 7'(i_q) + 7'(srg_pkg::LAG_OFS);
	assign mix_other = (other_sum >= 7'(srg_pkg::LEN)) ?
		IW'(other_sum - 7'(srg_pkg::LEN)) : IW'(other_sum);

	assign pos_sum = 7'(pos_q) + 7'(srg_pkg::SCATTER);
	assign pos_nxt = (pos_sum >= 7'(srg_pkg::LEN)) ?
		PW'(pos_sum - 7'(srg_pkg::LEN)) : PW'(pos_sum);

	assign lead_nxt  = (lead_q >= srg_pkg::LAST_POS) ? PW'(1) : lead_q + PW'(1);
	assign trail_nxt = (trail_q >= srg_pkg::LAST_POS) ? PW'(1) : trail_q + PW'(1);

	assign div_t = 32'(s_q[WW-1:0]) + 32'(s_q[32:31]);
	assign div_c = (div_t >= 32'(srg_pkg::MOD));
	assign q_sel = neg_q ? ~q_q[31:0] : q_q[31:0];

	srg_ram #(
		.WIDTH(WW),
		.DEPTH(srg_pkg::LEN)
	) u_table (
		.clk    (clk),
		.we     (ram.we),
		.waddr  (ram.waddr),
		.wdata  (ram.wdata),
		.raddr_a(ram.raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(ram.raddr_b),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		ram.we      = 1'b0;
		ram.waddr   = '0;
		ram.wdata   = '0;
		ram.raddr_a = '0;
		ram.raddr_b = '0;
		if (mix_wr_s1) begin
			ram.we    = 1'b1;
			ram.waddr = mix_idx_s1;
			ram.wdata = srg_pkg::mod_sub(rdata_a, rdata_b);
		end
		case (state_q)
			srg_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = (command == srg_pkg::CMD_DRAW) ?
						srg_pkg::ST_DRAW_RD : srg_pkg::ST_SEED_DIFF;
				end
			end
			srg_pkg::ST_SEED_DIFF: begin
				state_nxt = srg_pkg::ST_SEED_FIRST;
			end
			srg_pkg::ST_SEED_FIRST: begin
				ram.we    = 1'b1;
				ram.waddr = IW'(srg_pkg::LEN - 1);
				ram.wdata = seed_cur;
				state_nxt = srg_pkg::ST_FILL;
			end
			srg_pkg::ST_FILL: begin
				ram.we    = 1'b1;
				ram.waddr = IW'(pos_q - PW'(1));
				ram.wdata = prev_q;
				if (i_q == srg_pkg::LAST_FILL) begin
					state_nxt = srg_pkg::ST_MIX;
				end
			end
			srg_pkg::ST_MIX: begin
				ram.raddr_a = IW'(i_q - PW'(1));
				ram.raddr_b = mix_other;
				if (pass_q == 2'd3 && i_q == srg_pkg::LAST_POS) begin
					state_nxt = srg_pkg::ST_MIX_DRAIN;
				end
			end
			srg_pkg::ST_MIX_DRAIN: begin
				state_nxt = srg_pkg::ST_IDLE;
			end
			srg_pkg::ST_DRAW_RD: begin
				ram.raddr_a = IW'(lead_q - PW'(1));
				ram.raddr_b = IW'(trail_q - PW'(1));
				state_nxt   = srg_pkg::ST_DRAW_SUB;
			end
			srg_pkg::ST_DRAW_SUB: begin
				ram.we    = 1'b1;
				ram.waddr = IW'(lead_q - PW'(1));
				ram.wdata = draw_r;
				state_nxt = srg_pkg::ST_DRAW_MUL;
			end
			srg_pkg::ST_DRAW_MUL: begin
				state_nxt = srg_pkg::ST_DRAW_DIV1;
			end
			srg_pkg::ST_DRAW_DIV1: begin
				state_nxt = srg_pkg::ST_DRAW_DIV2;
			end
			srg_pkg::ST_DRAW_DIV2: begin
				state_nxt = srg_pkg::ST_DRAW_OUT;
			end
			srg_pkg::ST_DRAW_OUT: begin
				state_nxt = srg_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = srg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q  <= 1'b0;
			valid_q   <= 1'b0;
			mix_wr_s1 <= 1'b0;
			lead_q    <= '0;
			trail_q   <= '0;
			i_q       <= '0;
			pos_q     <= '0;
			pass_q    <= '0;
		end else begin
			valid_q   <= (state_q == srg_pkg::ST_DRAW_OUT);
			mix_wr_s1 <= (state_q == srg_pkg::ST_MIX);
			case (state_q)
				srg_pkg::ST_IDLE: begin
					if (accept && command == srg_pkg::CMD_DRAW) begin
						lead_q  <= lead_nxt;
						trail_q <= trail_nxt;
					end
				end
				srg_pkg::ST_SEED_FIRST: begin
					i_q   <= PW'(1);
					pos_q <= srg_pkg::SCATTER;
				end
				srg_pkg::ST_FILL: begin
					pos_q <= pos_nxt;
					if (i_q == srg_pkg::LAST_FILL) begin
						i_q    <= PW'(1);
						pass_q <= '0;
					end else begin
						i_q <= i_q + PW'(1);
					end
				end
				srg_pkg::ST_MIX: begin
					if (i_q == srg_pkg::LAST_POS) begin
						i_q    <= PW'(1);
						pass_q <= pass_q + 2'd1;
					end else begin
						i_q <= i_q + PW'(1);
					end
				end
				srg_pkg::ST_MIX_DRAIN: begin
					seeded_q <= 1'b1;
					lead_q   <= '0;
					trail_q  <= srg_pkg::TRAIL_INIT;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mix_idx_s1 <= IW'(i_q - PW'(1));
		case (state_q)
			srg_pkg::ST_IDLE: begin
				seedabs_q <= seed_value[31] ? 32'(-seed_value) : 32'(seed_value);
				lo_q      <= 32'(range_low);
				range_q   <= 34'(range_high) - 34'(range_low) + 34'sd1;
			end
			srg_pkg::ST_SEED_DIFF: begin
				diff_q <= 33'(srg_pkg::SEED_CONST) - {1'b0, seedabs_q};
			end
			srg_pkg::ST_SEED_FIRST: begin
				cur_q  <= seed_cur;
				prev_q <= WW'(1);
			end
			srg_pkg::ST_FILL: begin
				// next cur is the word just written, next prev the difference
				prev_q <= srg_pkg::mod_sub(cur_q, prev_q);
				cur_q  <= prev_q;
			end
			srg_pkg::ST_DRAW_RD: begin
				neg_q  <= range_q[33];
				absr_q <= range_q[33] ? 33'(34'sd0 - range_q) : range_q[32:0];
			end
			srg_pkg::ST_DRAW_SUB: begin
				r_q <= draw_r;
			end
			srg_pkg::ST_DRAW_MUL: begin
				// a magnitude of 2^32 has all low bits clear
				mag_q <= absr_q[32] ? {r_q, 32'd0} : 63'(r_q) * 63'(absr_q[31:0]);
			end
			srg_pkg::ST_DRAW_DIV1: begin
				// x = a*2^31 + b = a*M + (a + b)
				a_q <= mag_q[62:31];
				s_q <= 33'(mag_q[62:31]) + 33'(mag_q[WW-1:0]);
			end
			srg_pkg::ST_DRAW_DIV2: begin
				q_q  <= 33'(a_q) + 33'(s_q[32:31]) + 33'(div_c);
				nz_q <= (div_t != 32'd0) && (div_t != 32'(srg_pkg::MOD));
			end
			srg_pkg::ST_DRAW_OUT: begin
				// floor of a negative quotient: -(q + nz) = ~q + !nz
				drawn_q <= q_sel + lo_q + 32'(neg_q & ~nz_q);
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q == srg_pkg::ST_DRAW_OUT))
		else $error("result strobe without a finished draw");

	assert property (@(posedge clk) disable iff (!arst_n)
		(mix_wr_s1 && state_q == srg_pkg::ST_MIX) |->
			(mix_idx_s1 != ram.raddr_a && mix_idx_s1 != ram.raddr_b))
		else $error("mixing write overlaps a read of the same entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srg_pkg::ST_DRAW_RD) |->
			(lead_q >= PW'(1) && lead_q <= srg_pkg::LAST_POS &&
			 trail_q >= PW'(1) && trail_q <= srg_pkg::LAST_POS))
		else $error("draw pointer outside the table");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srg_pkg::ST_MIX_DRAIN) |=> (lead_q == '0 && trail_q == srg_pkg::TRAIL_INIT))
		else $error("pointers not set after reseed");

endmodule

`default_nettype wire

// ----- sv/srg_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module srg_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 55,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	output logic      [WIDTH-1:0]  rdata_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int unsigned TAB_LEN = srg_pkg::LEN;
	localparam int unsigned WW      = srg_pkg::WORD_W;
	localparam int unsigned PW      = srg_pkg::PTR_W;

	localparam longint MODULUS = longint'(srg_pkg::MOD);

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               command;
	logic signed [31:0] seed_value;
	logic signed [31:0] range_low;
	logic signed [31:0] range_high;
	logic               valid;
	logic signed [31:0] drawn_value;

	// predictor state: entry k stands for table position k+1
	logic [WW-1:0]      lag_words [TAB_LEN];
	logic [PW-1:0]      lead_pos;
	logic [PW-1:0]      trail_pos;

	logic signed [31:0] drawn_expect [$];
	int                 errors;
	bit                 steady_mode;

	subtractive_random_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.seed_value (seed_value),
		.range_low  (range_low),
		.range_high (range_high),
		.valid      (valid),
		.drawn_value(drawn_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [WW-1:0] wrap_sub(input longint a, input longint b);
		longint d;
		d = a - b;
		if (d < 0)
			d = d + MODULUS;
		return d[WW-1:0];
	endfunction

	function automatic void predict_reseed(input logic signed [31:0] s);
		longint mag;
		longint t;
		longint cur;
		longint prev;
		int     pos;
		int     other;
		mag = longint'(s);
		if (mag < 0)
			mag = -mag;
		t = longint'(srg_pkg::SEED_CONST) - mag;
		if (t < 0)
			t = -t;
		cur = t % MODULUS;
		lag_words[srg_pkg::LAST_POS-1] = cur[WW-1:0];
		prev = 1;
		for (int i = 1; i <= int'(srg_pkg::LAST_FILL); i++) begin
			pos = (int'(srg_pkg::SCATTER) * i) % int'(TAB_LEN);
			lag_words[pos-1] = prev[WW-1:0];
			prev = longint'(wrap_sub(cur, prev));
			cur = longint'(lag_words[pos-1]);
		end
		repeat (4) begin
			for (int i = 1; i <= int'(TAB_LEN); i++) begin
				other = 1 + (i + int'(srg_pkg::LAG_OFS)) % int'(TAB_LEN);
				lag_words[i-1] = wrap_sub(longint'(lag_words[i-1]),
					longint'(lag_words[other-1]));
			end
		end
		lead_pos = '0;
		trail_pos = srg_pkg::TRAIL_INIT;
	endfunction

	function automatic logic signed [31:0] predict_draw(input logic signed [31:0] lo,
		input logic signed [31:0] hi);
		logic [WW-1:0] r;
		longint        span;
		longint        prod;
		longint        q;
		longint        sum;
		lead_pos = (lead_pos + 1 >= TAB_LEN + 1) ? PW'(1) : PW'(lead_pos + 1);
		trail_pos = (trail_pos + 1 >= TAB_LEN + 1) ? PW'(1) : PW'(trail_pos + 1);
		r = wrap_sub(longint'(lag_words[lead_pos-1]), longint'(lag_words[trail_pos-1]));
		lag_words[lead_pos-1] = r;
		span = longint'(hi) - longint'(lo) + 1;
		prod = longint'(r) * span;
		q = prod / MODULUS;
		// floor toward minus infinity
		if ((prod % MODULUS) != 0 && prod < 0)
			q = q - 1;
		sum = q + longint'(lo);
		return sum[31:0];
	endfunction

	// one transfer; returns at the falling edge after acceptance with start still high
	task automatic send_item(input logic cmd, input logic signed [31:0] s,
		input logic signed [31:0] lo, input logic signed [31:0] hi);
		command = cmd;
		seed_value = s;
		range_low = lo;
		range_high = hi;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		if (cmd == srg_pkg::CMD_DRAW)
			drawn_expect.push_back(predict_draw(lo, hi));
		else
			predict_reseed(s);
		@(negedge clk);
	endtask

	task automatic gap();
		if (!steady_mode && $urandom_range(99) < 35) begin
			start = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (drawn_expect.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0d", $time, drawn_value);
				errors++;
			end else if (drawn_value !== drawn_expect[0]) begin
				$display("%0t: drawn_value mismatch, expected %0d, got %0d",
					$time, drawn_expect[0], drawn_value);
				errors++;
				void'(drawn_expect.pop_front());
			end else begin
				void'(drawn_expect.pop_front());
			end
		end
	end

	task automatic test_unseeded_draw();
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sh8000_0000, 32'sh7FFF_FFFF);
		gap();
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sh7FFF_FFFF, 32'sh8000_0000);
		gap();
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sd12345, 32'sd99);
		gap();
	endtask

	task automatic test_seed_folding();
		send_item(srg_pkg::CMD_SEED, 32'sd0, $urandom, $urandom);
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sd0, 32'sh7FFF_FFFF);
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sd0, 32'sh7FFF_FFFF);
		gap();
		// most negative seed folds to 2^31
		send_item(srg_pkg::CMD_SEED, 32'sh8000_0000, $urandom, $urandom);
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sd1, 32'sd6);
		gap();
		send_item(srg_pkg::CMD_SEED, 32'sh7FFF_FFFF, $urandom, $urandom);
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sd0, 32'sd999);
		// seed equal to the constant gives a zero start value, either sign
		send_item(srg_pkg::CMD_SEED, 32'sd161803398, $urandom, $urandom);
		send_item(srg_pkg::CMD_DRAW, $urandom, -32'sd1000, 32'sd1000);
		gap();
		send_item(srg_pkg::CMD_SEED, -32'sd161803398, $urandom, $urandom);
		send_item(srg_pkg::CMD_DRAW, $urandom, -32'sd1000, 32'sd1000);
		gap();
	endtask

	task automatic test_range_shapes();
		send_item(srg_pkg::CMD_SEED, -32'sd1, $urandom, $urandom);
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sd77, 32'sd77);
		// empty range: hi one below lo
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sd500, 32'sd499);
		gap();
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sd0, 32'sd0);
		send_item(srg_pkg::CMD_DRAW, $urandom, 32'sd1, 32'sd6);
		gap();
	endtask

	task automatic test_drain_pause();
		repeat (4) begin
			send_item(srg_pkg::CMD_DRAW, $urandom, $urandom, $urandom);
			gap();
		end
		start = 1'b0;
		while (drawn_expect.size() != 0)
			@(negedge clk);
		send_item(srg_pkg::CMD_DRAW, $urandom, -32'sd5, 32'sd5);
		send_item(srg_pkg::CMD_DRAW, $urandom, -32'sd5, 32'sd5);
		gap();
	endtask

	task automatic test_random_traffic();
		int                 sent;
		int                 burst;
		logic signed [31:0] s;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		sent = 0;
		while (sent < 400) begin
			steady_mode = (sent >= 150 && sent < 240);
			if ($urandom_range(99) < 85) begin
				case ($urandom_range(9))
					0: s = 32'sh8000_0000;
					1: s = 32'sh7FFF_FFFF;
					2: s = 32'sd0;
					default: s = $urandom;
				endcase
				send_item(srg_pkg::CMD_SEED, s, $urandom, $urandom);
				gap();
				sent++;
				burst = $urandom_range(3, 25);
			end else if ($urandom_range(1) == 0) begin
				send_item(srg_pkg::CMD_SEED, $urandom, $urandom, $urandom);
				gap();
				sent++;
				burst = 0;
			end else begin
				burst = 1;
			end
			repeat (burst) begin
				lo = $urandom;
				case ($urandom_range(5))
					0: hi = lo + $urandom_range(0, 1000);
					1: hi = $urandom;
					2: hi = lo;
					3: hi = lo - $urandom_range(1, 1000);
					4: begin
						lo = 32'sh8000_0000;
						hi = 32'sh7FFF_FFFF;
					end
					default: begin
						lo = $urandom_range(0, 20);
						hi = $urandom;
					end
				endcase
				send_item(srg_pkg::CMD_DRAW, $urandom, lo, hi);
				gap();
				sent++;
			end
		end
		steady_mode = 1'b0;
	endtask

	initial begin
		errors = 0;
		steady_mode = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = srg_pkg::CMD_DRAW;
		seed_value = '0;
		range_low = '0;
		range_high = '0;
		for (int k = 0; k < int'(TAB_LEN); k++)
			lag_words[k] = '0;
		lead_pos = '0;
		trail_pos = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_unseeded_draw();
		test_seed_folding();
		test_range_shapes();
		test_drain_pause();
		test_random_traffic();

		start = 1'b0;
		while (drawn_expect.size() != 0)
			@(negedge clk);
		// a trailing reseed keeps the block busy through its fill and mixing steps
		repeat (300) @(negedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
